// File: hw/rtl/pbd_pkg.sv
// Package for the packed block dequantizer: payload structs, codes and widths.
// Used by pbd_lane.sv and packed_block_dequantizer_core.sv; depends on nothing.
package pbd_pkg;

  localparam int unsigned LaneCount = 4;
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  typedef enum logic [1:0] {
    KindByte     = 2'd0,
    KindUint4    = 2'd1,
    KindInt4     = 2'd2,
    KindReserved = 2'd3
  } data_kind_e;

  typedef enum logic [1:0] {
    RegElementBits = 2'd0,
    RegDataKind    = 2'd1,
    RegZeroPoints  = 2'd2
  } reg_index_e;

  typedef struct packed {
    logic [7:0]  packed_byte;
    logic [31:0] scale_word;
    logic [7:0]  zero_byte;
    logic [1:0]  zero_slot;
  } req_t;

  typedef struct packed {
    logic [31:0] value_lane0;
    logic [31:0] value_lane1;
    logic [31:0] value_lane2;
    logic [31:0] value_lane3;
    logic [2:0]  lanes_valid;
  } rsp_t;

endpackage

// File: hw/rtl/pbd_lane.sv
// One dequantizer lane: signed difference (-255..255) times an fp32 scale, RNE.
// Two register stages (significand product, then normalise/round). Uses pbd_pkg.
module pbd_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [8:0]  diff_i,
  input  logic [31:0] scale_i,
  output logic [31:0] value_o
);

  logic        s_sign;
  logic [7:0]  s_exp;
  logic [22:0] s_man;
  logic [7:0]  d_mag;
  logic        sign_d;

  assign s_sign = scale_i[31];
  assign s_exp  = scale_i[30:23];
  assign s_man  = scale_i[22:0];
  assign d_mag  = diff_i[8] ? 8'(-diff_i) : diff_i[7:0];
  assign sign_d = s_sign ^ diff_i[8];

  // Stage 1: classify and multiply the significands.
  logic        sign_q, nan_q, inf_q, zero_q;
  logic [31:0] prod_q;
  logic [9:0]  exp_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sign_q <= sign_d;
      nan_q  <= (s_exp == 8'hFF && s_man != '0) || (s_exp == 8'hFF && d_mag == '0);
      inf_q  <= (s_exp == 8'hFF);
      zero_q <= (d_mag == '0) || (s_exp == '0 && s_man == '0);
      prod_q <= 32'({(s_exp != '0), s_man}) * 32'(d_mag);
      exp_q  <= (s_exp == '0) ? 10'd1 : {2'b00, s_exp};
    end
  end

  // Stage 2: normalise. Product value = prod * 2^(exp-150).
  logic [5:0]  lz;
  logic [31:0] norm;
  logic signed [11:0] e_un;
  logic [5:0]  rsh;
  logic [55:0] wide, shifted;
  logic [23:0] mant;
  logic        g, st, up;
  logic [24:0] mr;
  logic signed [11:0] e_fin;
  logic [31:0] res_d;

  always_comb begin
    lz = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (prod_q[i]) lz = 6'(31 - i);
    end
    norm  = prod_q << lz[4:0];
    // value = 1.f * 2^(exp - 150 + 31 - lz); biased exponent = exp + 8 - lz
    e_un  = $signed({2'b00, exp_q}) + 12'sd8 - $signed({6'b0, lz});
    rsh   = 6'd0;
    if (e_un < 12'sd1) begin
      rsh = (e_un < -12'sd30) ? 6'd31 : 6'(12'sd1 - e_un);
    end
    wide    = {norm, 24'b0};
    shifted = wide >> rsh;
    mant    = shifted[55:32];
    g       = shifted[31];
    st      = (shifted[30:0] != '0);
    up      = g & (st | mant[0]);
    mr      = {1'b0, mant} + 25'(up);
    e_fin   = (rsh != '0) ? 12'sd0 : e_un;
    res_d   = '0;
    if (mr[24]) begin
      e_fin = e_fin + 12'sd1;
      mr    = mr >> 1;
    end else if (rsh != '0 && mr[23]) begin
      e_fin = 12'sd1;
    end
    if (nan_q) begin
      res_d = pbd_pkg::CanonNan;
    end else if (inf_q || e_fin >= 12'sd255) begin
      res_d = {sign_q, 8'hFF, 23'b0};
    end else if (zero_q) begin
      res_d = {sign_q, 31'b0};
    end else begin
      res_d = {sign_q, e_fin[7:0], mr[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_o <= res_d;
    end
  end

endmodule

// File: hw/rtl/packed_block_dequantizer_core.sv
// Top level of the packed block dequantizer: config registers, code unpacking,
// four pbd_lane instances and the merging output stage. Uses pbd_pkg, pbd_lane.
//
// Usage: raise start with a request on req_i whenever busy is low; busy is
// never raised, so one request is taken every cycle. The result of a request
// appears on rsp_o with done_o high for exactly one cycle, once the unpack
// register, lane product register and lane rounding register have fed the
// merge register. The receiver cannot stall. Configuration writes via
// cfg_we_i/cfg_idx_i/cfg_wdata_i take effect at once; write only when idle.
module packed_block_dequantizer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pbd_pkg::req_t req_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [3:0]    cfg_wdata_i,
  output logic          done_o,
  output pbd_pkg::rsp_t rsp_o
);

  logic [3:0] elem_bits_q;
  logic [1:0] kind_q;
  logic       zp_q;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_bits_q <= 4'd4;
      kind_q      <= pbd_pkg::KindByte;
      zp_q        <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbd_pkg::RegElementBits: elem_bits_q <= cfg_wdata_i;
        pbd_pkg::RegDataKind:    kind_q      <= cfg_wdata_i[1:0];
        pbd_pkg::RegZeroPoints:  zp_q        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Unpack: work out code width and the signed differences per lane.
  logic        w4_bit, w8_bit, w2_bit, sgn;
  logic signed [9:0] zp_val;
  logic signed [9:0] code [pbd_pkg::LaneCount];
  logic [8:0]  diff_d [pbd_pkg::LaneCount];
  logic [2:0]  lanes_d;
  logic [3:0]  znib;

  always_comb begin
    sgn    = (kind_q == pbd_pkg::KindInt4);
    w2_bit = 1'b0;
    w8_bit = 1'b0;
    if (kind_q == pbd_pkg::KindUint4 || kind_q == pbd_pkg::KindInt4) begin
      w4_bit = 1'b1;
    end else begin
      w2_bit = (elem_bits_q == 4'd2);
      w8_bit = (elem_bits_q == 4'd8);
      w4_bit = !w2_bit && !w8_bit;
    end
    lanes_d = w8_bit ? 3'd1 : (w4_bit ? 3'd2 : 3'd4);
    znib    = req_i.zero_slot[0] ? req_i.zero_byte[7:4] : req_i.zero_byte[3:0];
    if (zp_q) begin
      if (w8_bit)      zp_val = {2'b00, req_i.zero_byte};
      else if (w4_bit) zp_val = {{6{sgn & znib[3]}}, znib};
      else             zp_val = 10'(req_i.zero_byte >> {req_i.zero_slot, 1'b0}) & 10'd3;
    end else if (kind_q == pbd_pkg::KindUint4 || kind_q == pbd_pkg::KindInt4) begin
      zp_val = '0;
    end else begin
      zp_val = w8_bit ? 10'sd128 : (w4_bit ? 10'sd8 : 10'sd2);
    end
    for (int k = 0; k < pbd_pkg::LaneCount; k++) begin
      if (w8_bit) begin
        code[k] = {2'b00, req_i.packed_byte};
      end else if (w4_bit) begin
        code[k] = {{6{sgn & req_i.packed_byte[4*(k%2)+3]}},
                   req_i.packed_byte[4*(k%2) +: 4]};
      end else begin
        code[k] = {8'b0, req_i.packed_byte[2*k +: 2]};
      end
      diff_d[k] = 9'(code[k] - zp_val);
    end
  end

  logic [8:0]  diff_q [pbd_pkg::LaneCount];
  logic [31:0] scale_q;
  logic [2:0]  lanes_q [3];
  logic [2:0]  vld_q;

  // Advance the valid and lane-count pipe alongside the lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start};
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q     <= diff_d;
    scale_q    <= req_i.scale_word;
    lanes_q[0] <= lanes_d;
    lanes_q[1] <= lanes_q[0];
    lanes_q[2] <= lanes_q[1];
  end

  logic [31:0] lane_val [pbd_pkg::LaneCount];

  for (genvar k = 0; k < pbd_pkg::LaneCount; k++) begin : g_lane
    pbd_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (1'b1),
      .diff_i (diff_q[k]),
      .scale_i(scale_q),
      .value_o(lane_val[k])
    );
  end

  // Merge: drop unused lanes to zero and register the result.
  logic  done_q;
  pbd_pkg::rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q.value_lane0 <= lane_val[0];
    rsp_q.value_lane1 <= (lanes_q[2] >= 3'd2) ? lane_val[1] : '0;
    rsp_q.value_lane2 <= (lanes_q[2] == 3'd4) ? lane_val[2] : '0;
    rsp_q.value_lane3 <= (lanes_q[2] == 3'd4) ? lane_val[3] : '0;
    rsp_q.lanes_valid <= lanes_q[2];
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: dv/packed_block_dequantizer_core_tb.sv
// Self-checking testbench for packed_block_dequantizer_core: predicts each request's fp32 lanes
// and compares them with the results on done_o. Depends on pbd_pkg and the core.
module packed_block_dequantizer_core_tb;

  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomItems   = 1100;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  pbd_pkg::req_t req_i;
  logic          cfg_we_i;
  logic [1:0]    cfg_idx_i;
  logic [3:0]    cfg_wdata_i;
  logic          done_o;
  pbd_pkg::rsp_t rsp_o;

  // Shadow copy of the configuration registers, masked as the block stores them.
  logic [3:0] cfg_element_bits;
  logic [1:0] cfg_data_kind;
  logic       cfg_zero_points;

  pbd_pkg::rsp_t pending_lanes[$];
  int unsigned   mismatch_count;
  bit            run_failed;
  int unsigned   quiet_cycles;

  packed_block_dequantizer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Exact product of a small integer and an fp32 scale, rounded to nearest even.
  function automatic logic [31:0] scale_by_int(int diff, logic [31:0] scale);
    logic        sgn;
    longint      mag;
    longint      sig;
    longint      prod;
    longint      q;
    longint      rem;
    longint      half;
    int          expo;
    int          msb;
    int          biased;
    int          sh;
    sgn  = scale[31] ^ (diff < 0);
    mag  = (diff < 0) ? -diff : diff;
    if (scale[30:23] == 8'hFF) begin
      if (scale[22:0] != 0 || mag == 0) return pbd_pkg::CanonNan;
      return {sgn, 8'hFF, 23'd0};
    end
    if (mag == 0 || scale[30:0] == 0) return {sgn, 31'd0};
    sig  = (scale[30:23] == 0) ? longint'(scale[22:0]) : longint'({1'b1, scale[22:0]});
    expo = (scale[30:23] == 0) ? 1 : int'(scale[30:23]);
    prod = mag * sig;
    msb  = 0;
    for (int b = 0; b < 40; b++) if (prod[b]) msb = b;
    biased = msb + expo - 23;
    if (biased < 1) begin
      // Subnormal range: the product is exact at this scale, no rounding.
      q = prod << (expo - 1);
      return {sgn, 8'd0, q[22:0]};
    end
    if (msb > 23) begin
      sh   = msb - 23;
      q    = prod >> sh;
      rem  = prod & ((longint'(1) << sh) - 1);
      half = longint'(1) << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
      if (q == (longint'(1) << 24)) begin
        q = q >> 1;
        biased++;
      end
    end else begin
      q = prod << (23 - msb);
    end
    if (biased >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, biased[7:0], q[22:0]};
  endfunction

  function automatic int nibble_value(logic [7:0] v, bit is_signed);
    if (is_signed && v[3]) return int'(v[3:0]) - 16;
    return int'(v[3:0]);
  endfunction

  function automatic pbd_pkg::rsp_t dequantize(pbd_pkg::req_t r);
    pbd_pkg::rsp_t res;
    int          width;
    int          lanes;
    int          zp;
    int          code;
    bit          is_signed;
    bit          byte_kind;
    logic [31:0] lane_val[4];
    byte_kind = !(cfg_data_kind == pbd_pkg::KindUint4 || cfg_data_kind == pbd_pkg::KindInt4);
    is_signed = (cfg_data_kind == pbd_pkg::KindInt4);
    if (!byte_kind) width = 4;
    else if (cfg_element_bits == 4'd2) width = 2;
    else if (cfg_element_bits == 4'd8) width = 8;
    else width = 4;
    lanes = 8 / width;
    if (cfg_zero_points) begin
      if (width == 8) zp = int'(r.zero_byte);
      else if (width == 4) zp = nibble_value(r.zero_slot[0] ? r.zero_byte >> 4 : r.zero_byte,
                                             is_signed);
      else zp = int'((r.zero_byte >> (2 * r.zero_slot)) & 8'h03);
    end else begin
      zp = byte_kind ? (1 << (width - 1)) : 0;
    end
    for (int k = 0; k < 4; k++) begin
      lane_val[k] = 32'd0;
      if (k < lanes) begin
        if (width == 8) code = int'(r.packed_byte);
        else if (width == 4) code = nibble_value(r.packed_byte >> (4 * k), is_signed);
        else code = int'((r.packed_byte >> (2 * k)) & 8'h03);
        lane_val[k] = scale_by_int(code - zp, r.scale_word);
      end
    end
    res.value_lane0 = lane_val[0];
    res.value_lane1 = lane_val[1];
    res.value_lane2 = lane_val[2];
    res.value_lane3 = lane_val[3];
    res.lanes_valid = 3'(lanes);
    return res;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      run_failed = 1'b1;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %h, got %h", field, want, got);
    end
  endfunction

  // Predict on every accepted request, check every result against the oldest prediction.
  always @(posedge clk_i) begin
    pbd_pkg::rsp_t want;
    if (rst_ni) begin
      if (start && !busy) pending_lanes.insert(pending_lanes.size(), dequantize(req_i));
      if (done_o) begin
        if (pending_lanes.size() == 0) begin
          mismatch_count++;
          run_failed = 1'b1;
          if (mismatch_count <= 10) $display("unexpected result %h", rsp_o);
        end else begin
          want = pending_lanes.pop_front();
          compare_field("value_lane0", want.value_lane0, rsp_o.value_lane0);
          compare_field("value_lane1", want.value_lane1, rsp_o.value_lane1);
          compare_field("value_lane2", want.value_lane2, rsp_o.value_lane2);
          compare_field("value_lane3", want.value_lane3, rsp_o.value_lane3);
          compare_field("lanes_valid", 32'(want.lanes_valid), 32'(rsp_o.lanes_valid));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Send one request; hold it until an edge at which busy is low.
  task automatic send_request(pbd_pkg::req_t r);
    logic was_busy;
    start <= 1'b1;
    req_i <= r;
    do begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
    end while (was_busy);
  endtask

  task automatic idle_for(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drop start, wait for every prediction to be met, then let the pipeline settle.
  task automatic drain_results();
    idle_for(1);
    while (pending_lanes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(pbd_pkg::reg_index_e idx, logic [3:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      pbd_pkg::RegElementBits: cfg_element_bits = value;
      pbd_pkg::RegDataKind:    cfg_data_kind = value[1:0];
      pbd_pkg::RegZeroPoints:  cfg_zero_points = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [3:0] bits, logic [3:0] kind, logic [3:0] zps);
    drain_results();
    write_reg(pbd_pkg::RegElementBits, bits);
    write_reg(pbd_pkg::RegDataKind, kind);
    write_reg(pbd_pkg::RegZeroPoints, zps);
  endtask

  function automatic logic [31:0] random_scale();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {1'($urandom()), 8'd0, 23'($urandom())};
      2: return {1'($urandom()), 8'hFF, ($urandom_range(0, 1) ? 23'd0 : 23'($urandom()))};
      3: return {1'($urandom()), 8'($urandom_range(240, 254)), 23'($urandom())};
      4: return {1'($urandom()), 8'($urandom_range(1, 12)), 23'($urandom())};
      5: return {1'($urandom()), 31'd0};
      default: return {1'($urandom()), 8'($urandom_range(100, 150)), 23'($urandom())};
    endcase
  endfunction

  function automatic pbd_pkg::req_t random_request();
    pbd_pkg::req_t r;
    r.packed_byte = 8'($urandom());
    r.scale_word  = random_scale();
    r.zero_byte   = 8'($urandom());
    r.zero_slot   = 2'($urandom());
    return r;
  endfunction

  task automatic test_reset();
    start       <= 1'b0;
    req_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= pbd_pkg::RegElementBits;
    cfg_wdata_i <= 4'd0;
    rst_ni      <= 1'b0;
    cfg_element_bits = 4'd4;
    cfg_data_kind    = pbd_pkg::KindByte;
    cfg_zero_points  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Field extremes and special scales: zero, signed zero, infinities, NaN, overflow,
  // subnormals; run under the reset setting and then a few others.
  task automatic test_directed();
    logic [31:0] scales[12] = '{32'h3F80_0000, 32'hBF80_0000, 32'h0000_0000, 32'h8000_0000,
                                32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'h7F80_0001,
                                32'h7F7F_FFFF, 32'h0000_0001, 32'h0080_0000, 32'h3F80_0001};
    pbd_pkg::req_t r;
    for (int i = 0; i < 12; i++) begin
      r.packed_byte = (i % 2) ? 8'hFF : 8'h00;
      r.scale_word  = scales[i];
      r.zero_byte   = (i % 3 == 0) ? 8'hFF : 8'h5A;
      r.zero_slot   = 2'(i);
      send_request(r);
    end
    apply_setting(4'd8, 4'(pbd_pkg::KindByte), 4'd1);
    for (int i = 0; i < 4; i++) begin
      r = '{packed_byte: 8'h80 + 8'(i), scale_word: scales[i * 3],
            zero_byte: 8'h80, zero_slot: 2'(i)};
      send_request(r);
    end
    apply_setting(4'd2, 4'(pbd_pkg::KindInt4), 4'd1);
    for (int i = 0; i < 4; i++) begin
      r = '{packed_byte: 8'h87, scale_word: scales[i], zero_byte: 8'h8F, zero_slot: 2'(i)};
      send_request(r);
    end
    apply_setting(4'd2, 4'(pbd_pkg::KindByte), 4'd1);
    for (int i = 0; i < 4; i++) begin
      r = '{packed_byte: 8'hE4, scale_word: 32'h4000_0000, zero_byte: 8'hE4, zero_slot: 2'(i)};
      send_request(r);
    end
  endtask

  // Bursts of random requests with random gaps, over one register setting.
  task automatic run_random_phase(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_request(random_request());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
    end
  endtask

  task automatic test_random_settings();
    logic [3:0] bits_set[6] = '{4'd2, 4'd4, 4'd8, 4'd0, 4'd15, 4'd5};
    int unsigned per_phase;
    per_phase = RandomItems / 30;
    for (int k = 0; k < 4; k++) begin
      for (int z = 0; z < 2; z++) begin
        for (int b = 0; b < 3; b++) begin
          apply_setting(bits_set[(k == 0) ? b : (b + 3 * (k % 2))], 4'(k), 4'(z));
          run_random_phase(per_phase);
        end
      end
    end
  endtask

  // Random register values, including ones outside the documented range.
  task automatic test_random_registers();
    for (int p = 0; p < 6; p++) begin
      apply_setting(4'($urandom()), 4'($urandom()), 4'($urandom()));
      run_random_phase(30);
    end
  endtask

  // Hold requests until every result is back, then resume.
  task automatic test_drain_pause();
    run_random_phase(20);
    idle_for(1);
    while (pending_lanes.size() != 0) @(posedge clk_i);
    run_random_phase(20);
  endtask

  initial begin
    mismatch_count = 0;
    run_failed     = 1'b0;
    test_reset();
    test_directed();
    test_random_settings();
    test_random_registers();
    test_drain_pause();
    drain_results();
    if (!run_failed && pending_lanes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_lanes.size() != 0) $display("%0d results missing", pending_lanes.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
